// ===== sv/bpem_pkg.sv =====
package bpem_pkg;

    localparam int SAMPLE_BITS = 14;
    localparam int LEVEL_W     = 16;
    localparam int HYST_W      = 13;
    localparam int WINDOW_W    = 13;
    localparam int SCALE_W     = 16;
    localparam int EDGE_W      = 14;
    localparam int ENERGY_W    = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = EDGE_W + SCALE_W;
    localparam int FRAC_BITS   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_SCALE  = 2'd2;

    localparam logic [HYST_W-1:0]   HYST_RESET   = 13'd10;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 13'd4096;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd11517;

    localparam logic signed [LEVEL_W-1:0] LOW_RESET  = 16'sh7fff;
    localparam logic signed [LEVEL_W-1:0] HIGH_RESET = 16'sh8000;

    localparam logic [EDGE_W-1:0]   EDGE_MAX   = 14'h3fff;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = 15'h7fff;

endpackage

// ===== sv/bpem_level_tracker.sv =====
module bpem_level_tracker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   fire,
    input  logic signed [bpem_pkg::SAMPLE_BITS-1:0] sample,
    input  logic        [bpem_pkg::HYST_W-1:0]      hysteresis,
    output logic                                   rise
);
    import bpem_pkg::*;

    localparam int SUM_W = LEVEL_W + 1;
    localparam int CEN_W = LEVEL_W + 2;

    logic signed [LEVEL_W-1:0] low_level_reg, low_level_next;
    logic signed [LEVEL_W-1:0] high_level_reg, high_level_next;
    logic                      light_on_reg, light_on_next;

    logic signed [LEVEL_W-1:0] s_ext;
    logic signed [LEVEL_W-1:0] lo_min;
    logic signed [LEVEL_W-1:0] hi_max;
    logic signed [SUM_W-1:0]   level_sum;
    logic signed [SUM_W-1:0]   mid;
    logic signed [CEN_W-1:0]   centered;
    logic signed [CEN_W-1:0]   hyst_pos;
    logic signed [CEN_W-1:0]   hyst_neg;

    always_comb
    begin
        s_ext     = LEVEL_W'(sample);
        lo_min    = (s_ext < low_level_reg) ? s_ext : low_level_reg;
        hi_max    = (s_ext > high_level_reg) ? s_ext : high_level_reg;
        level_sum = SUM_W'(lo_min) + SUM_W'(hi_max);
        // halve with truncation toward zero
        mid       = (level_sum >>> 1) +
                    $signed(SUM_W'(level_sum[SUM_W-1] & level_sum[0]));
        centered  = CEN_W'(s_ext) - CEN_W'(mid);
        hyst_pos  = $signed(CEN_W'(hysteresis));
        hyst_neg  = -hyst_pos;

        light_on_next = light_on_reg;
        if (centered < hyst_neg)
        begin
            light_on_next = 1'b0;
        end
        else if (centered > hyst_pos)
        begin
            light_on_next = 1'b1;
        end

        // extremes leak one step toward zero
        low_level_next  = lo_min[LEVEL_W-1] ? lo_min + LEVEL_W'(1) : lo_min;
        high_level_next = (!hi_max[LEVEL_W-1] && (hi_max != '0)) ?
                          hi_max - LEVEL_W'(1) : hi_max;

        rise = fire && !light_on_reg && light_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_level_reg  <= LOW_RESET;
            high_level_reg <= HIGH_RESET;
            light_on_reg   <= 1'b0;
        end
        else if (fire)
        begin
            low_level_reg  <= low_level_next;
            high_level_reg <= high_level_next;
            light_on_reg   <= light_on_next;
        end
    end

endmodule

// ===== sv/blink_pulse_energy_meter_unit.sv =====
// Blink pulse energy meter. Each accepted sample transaction updates the
// running extremes, the light-on flag and the blink and sample counters,
// so a sample can be taken every clock. When window_length samples
// have been counted the next sample closes the window, and if any blinks were
// seen one result carries the blink count and (blinks * energy_scale) >> 8,
// saturated at 32767. The result sits in an output register; samples that
// do not close a window keep being accepted while it waits, and a sample
// that would close one waits only until the pending result is taken.
// Configuration writes are always accepted and should be made while idle.
module blink_pulse_energy_meter_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [bpem_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic        [bpem_pkg::ENERGY_W-1:0]    energy_wh,
    output logic        [bpem_pkg::EDGE_W-1:0]      blinks_in_window,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [bpem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [bpem_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bpem_pkg::*;

    localparam int SHIFTED_W = PROD_W - FRAC_BITS;

    logic [HYST_W-1:0]   hysteresis_reg;
    logic [WINDOW_W-1:0] window_length_reg;
    logic [SCALE_W-1:0]  energy_scale_reg;

    logic [EDGE_W-1:0]   edge_count_reg, edge_count_next;
    logic [WINDOW_W-1:0] sample_count_reg, sample_count_next;

    logic                out_valid_reg, out_valid_next;
    logic [ENERGY_W-1:0] energy_reg;
    logic [EDGE_W-1:0]   blinks_reg;

    logic                in_fire;
    logic                cfg_fire;
    logic                out_fire;
    logic                close;
    logic                emit;
    logic                rise;
    logic [PROD_W-1:0]   product;
    logic [SHIFTED_W-1:0] shifted;
    logic [ENERGY_W-1:0] energy_sat;
    logic [EDGE_W-1:0]   edge_base;

    bpem_level_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .sample     (sample),
        .hysteresis (hysteresis_reg),
        .rise       (rise)
    );

    always_comb
    begin
        close    = (sample_count_reg >= window_length_reg);
        emit     = close && (edge_count_reg != '0);
        // only a window-closing sample with blinks needs room in the output register
        in_ready = !emit || !out_valid_reg || out_ready;
        in_fire  = in_valid && in_ready;
        out_fire = out_valid_reg && out_ready;
        cfg_ready = 1'b1;
        cfg_fire  = cfg_valid;

        product    = PROD_W'(edge_count_reg) * PROD_W'(energy_scale_reg);
        shifted    = product[PROD_W-1:FRAC_BITS];
        energy_sat = (shifted > SHIFTED_W'(ENERGY_MAX)) ? ENERGY_MAX :
                     shifted[ENERGY_W-1:0];

        if (close)
        begin
            edge_base         = '0;
            sample_count_next = '0;
        end
        else
        begin
            edge_base         = edge_count_reg;
            sample_count_next = sample_count_reg + WINDOW_W'(1);
        end
        edge_count_next = (rise && (edge_base != EDGE_MAX)) ?
                          edge_base + EDGE_W'(1) : edge_base;

        out_valid_next = out_valid_reg && !out_ready;
        if (in_fire && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hysteresis_reg    <= HYST_RESET;
            window_length_reg <= WINDOW_RESET;
            energy_scale_reg  <= SCALE_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_HYSTERESIS:    hysteresis_reg    <= cfg_data[HYST_W-1:0];
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data[WINDOW_W-1:0];
                CFG_ENERGY_SCALE:  energy_scale_reg  <= cfg_data[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg   <= '0;
            sample_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                edge_count_reg   <= edge_count_next;
                sample_count_reg <= sample_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            energy_reg <= energy_sat;
            blinks_reg <= edge_count_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign energy_wh        = energy_reg;
    assign blinks_in_window = blinks_reg;

`ifndef SYNTHESIS
    a_result_has_blinks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (blinks_reg != '0))
        else $error("result with zero blinks");

    a_close_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && close) |=> (sample_count_reg == '0))
        else $error("window close did not clear sample count");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && emit) |=> out_valid_reg)
        else $error("closed window result lost");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(in_fire && emit))
        else $error("pending result overwritten");
`endif

endmodule

// ===== tb/bpem_scoreboard.sv =====
`timescale 1ns / 100ps

module bpem_scoreboard (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic signed [bpem_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic        [bpem_pkg::ENERGY_W-1:0]    energy_wh,
    input  logic        [bpem_pkg::EDGE_W-1:0]      blinks_in_window,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic        [bpem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [bpem_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                      errors,
    output int                                      outstanding
);
    import bpem_pkg::*;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [EDGE_W-1:0]   blinks;
    } window_result_t;

    window_result_t            window_result_q[$];
    window_result_t            oldest;

    logic [HYST_W-1:0]         band_r;
    logic [WINDOW_W-1:0]       window_r;
    logic [SCALE_W-1:0]        scale_r;

    logic signed [LEVEL_W-1:0] floor_lvl;
    logic signed [LEVEL_W-1:0] peak_lvl;
    logic                      lit;
    logic [EDGE_W-1:0]         blink_cnt;
    logic [WINDOW_W-1:0]       sample_cnt;

    task automatic meter_sample(input logic signed [SAMPLE_BITS-1:0] s);
        int                          centered;
        int                          band;
        logic                        was_lit;
        logic [PROD_W-1:0]           prod;
        logic [PROD_W-FRAC_BITS-1:0] whole;
        window_result_t              res;
        logic signed [LEVEL_W-1:0]   s_lvl;
        s_lvl = LEVEL_W'(s);
        if (sample_cnt >= window_r)
        begin
            if (blink_cnt != '0)
            begin
                prod = PROD_W'(blink_cnt) * PROD_W'(scale_r);
                whole = prod[PROD_W-1:FRAC_BITS];
                res.energy = (whole > ENERGY_MAX) ? ENERGY_MAX : whole[ENERGY_W-1:0];
                res.blinks = blink_cnt;
                window_result_q.push_back(res);
            end
            blink_cnt = '0;
            sample_cnt = '0;
        end
        else
        begin
            sample_cnt = sample_cnt + WINDOW_W'(1);
        end

        if (s_lvl < floor_lvl)
            floor_lvl = s_lvl;
        if (s_lvl > peak_lvl)
            peak_lvl = s_lvl;
        // midpoint truncates toward zero, same as integer division
        centered = int'(s) - (int'(floor_lvl) + int'(peak_lvl)) / 2;
        band = int'(band_r);

        was_lit = lit;
        if (centered < -band)
            lit = 1'b0;
        else if (centered > band)
            lit = 1'b1;
        if (!was_lit && lit && blink_cnt != EDGE_MAX)
            blink_cnt = blink_cnt + EDGE_W'(1);

        // extremes leak one step toward zero
        if (floor_lvl < 0)
            floor_lvl = floor_lvl + LEVEL_W'(1);
        if (peak_lvl > 0)
            peak_lvl = peak_lvl - LEVEL_W'(1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_result_q.delete();
            band_r      = HYST_RESET;
            window_r    = WINDOW_RESET;
            scale_r     = SCALE_RESET;
            floor_lvl   = LOW_RESET;
            peak_lvl    = HIGH_RESET;
            lit         = 1'b0;
            blink_cnt   = '0;
            sample_cnt  = '0;
            errors      = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (window_result_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected: energy_wh=%0d blinks_in_window=%0d",
                             $time, energy_wh, blinks_in_window);
                end
                else
                begin
                    oldest = window_result_q.pop_front();
                    if (energy_wh !== oldest.energy)
                    begin
                        errors++;
                        $display("%0t: energy_wh expected %0d actual %0d",
                                 $time, oldest.energy, energy_wh);
                    end
                    if (blinks_in_window !== oldest.blinks)
                    begin
                        errors++;
                        $display("%0t: blinks_in_window expected %0d actual %0d",
                                 $time, oldest.blinks, blinks_in_window);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HYSTERESIS:    band_r   = cfg_data[HYST_W-1:0];
                    CFG_WINDOW_LENGTH: window_r = cfg_data[WINDOW_W-1:0];
                    CFG_ENERGY_SCALE:  scale_r  = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                meter_sample(sample);

            outstanding <= window_result_q.size();
        end
    end

endmodule

// ===== tb/tb_blink_pulse_energy_meter_unit.sv =====
`timescale 1ns / 100ps

module tb_blink_pulse_energy_meter_unit;
    import bpem_pkg::*;

    localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample    = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic        [ENERGY_W-1:0]    energy_wh;
    logic        [EDGE_W-1:0]      blinks_in_window;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic        [CFG_IDX_W-1:0]   cfg_index = '0;
    logic        [CFG_DATA_W-1:0]  cfg_data  = '0;

    int errors;
    int outstanding;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    blink_pulse_energy_meter_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .energy_wh        (energy_wh),
        .blinks_in_window (blinks_in_window),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    bpem_scoreboard i_scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .energy_wh        (energy_wh),
        .blinks_in_window (blinks_in_window),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .errors           (errors),
        .outstanding      (outstanding)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_stall_pct);

    // valid is only dropped when a gap is taken, so back-to-back transactions keep it high
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait out every pending window result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // square wave around an offset, half_len samples per level
    task automatic blink_train(input int n, input int amp, input int half_len,
                               input int noise, input int offset);
        int v;
        for (int i = 0; i < n; i++)
        begin
            v = offset + (((i / half_len) % 2) ? amp : -amp);
            if (noise > 0)
                v += int'($urandom_range(2 * noise)) - noise;
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            if (v < SAMPLE_MIN)
                v = SAMPLE_MIN;
            send_sample(SAMPLE_BITS'(v));
        end
    endtask

    task automatic mixed_samples(input int n);
        int sent;
        int len;
        int amp;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) < 8)
            begin
                len = $urandom_range(8, 40);
                amp = $urandom_range(300, SAMPLE_MAX);
                blink_train(len, amp, $urandom_range(1, 8), $urandom_range(0, amp / 4),
                            int'($urandom_range(0, 2000)) - 1000);
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    send_sample(SAMPLE_BITS'($urandom));
            end
            sent += len;
        end
    endtask

    initial
    begin
        int hyst;
        int win;
        int scale;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes at reset settings
        send_sample(SAMPLE_BITS'(SAMPLE_MIN));
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample('0);
        send_sample(SAMPLE_BITS'(-1));
        send_sample(SAMPLE_BITS'(1));
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample(SAMPLE_BITS'(SAMPLE_MIN));

        drain_results();
        write_reg(CFG_UNUSED, 16'hffff);
        // upper bits are dropped, leaving a zero window that closes on every sample
        write_reg(CFG_WINDOW_LENGTH, 16'he000);
        write_reg(CFG_HYSTERESIS, 16'he005);
        write_reg(CFG_ENERGY_SCALE, 16'hffff);
        for (int i = 0; i < 12; i++)
            send_sample((i % 2) ? SAMPLE_BITS'(SAMPLE_MAX) : SAMPLE_BITS'(SAMPLE_MIN));

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0:
                begin
                    hyst = 0;    win = 1;    scale = 0;
                end
                1:
                begin
                    hyst = 8191; win = 16;   scale = 11517;
                end
                2:
                begin
                    hyst = 50;   win = 8191; scale = 65535;
                end
                // shortened while the long window is still open
                3:
                begin
                    hyst = 20;   win = 3;    scale = 300;
                end
                // enough blinks in one window to saturate the energy
                4:
                begin
                    hyst = 4;    win = 300;  scale = 65535;
                end
                default:
                begin
                    hyst  = $urandom_range(0, 300);
                    win   = $urandom_range(2, 64);
                    scale = $urandom_range(0, 65535);
                end
            endcase

            drain_results();
            case (p % 4)
                0:
                begin
                    in_idle_pct = 0;  out_stall_pct = 0;
                end
                1:
                begin
                    in_idle_pct = 56; out_stall_pct = 0;
                end
                2:
                begin
                    in_idle_pct = 0;  out_stall_pct = 56;
                end
                default:
                begin
                    in_idle_pct = 18; out_stall_pct = 18;
                end
            endcase
            write_reg(CFG_HYSTERESIS, {3'($urandom), 13'(hyst)});
            write_reg(CFG_WINDOW_LENGTH, {3'($urandom), 13'(win)});
            write_reg(CFG_ENERGY_SCALE, 16'(scale));

            if (p == 4)
                blink_train(320, SAMPLE_MAX - 100, 1, 0, 0);
            else
                mixed_samples(80);
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
